/* src/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on the rising clock edge, masked during reset.
`define UISL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define UISL_ASSERT_IMP(label, ante, cons, msg) \
  `UISL_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define UISL_ASSERT_NEXT(label, ante, cons, msg) \
  `UISL_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* src/uisl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uisl_pkg
// Shared types and constants for the unique index set list.
// ----------------------------------------------------------------------------
package uisl_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int VERTEX_W     = 16;
  localparam int POS_W        = 8;
  localparam int COUNT_OUT_W  = 9;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESULT
  } state_t;

  // entry store write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } wr_t;

endpackage

/* src/uisl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uisl_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module uisl_ram (
  input  logic                        clk,
  input  uisl_pkg::wr_t               wr,
  input  logic [uisl_pkg::IDX_W-1:0]  rd_addr,
  output logic [uisl_pkg::IDX_W-1:0]  rd_data
);
  import uisl_pkg::*;

  logic [IDX_W-1:0] mem [MAX_VERTICES];
  logic [IDX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/uisl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uisl_ctrl
// Sequencer: linear search with one shared comparator, gap-closing shift on
// remove, fill count and result register.
// ----------------------------------------------------------------------------
module uisl_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_command,
  input  logic [uisl_pkg::VERTEX_W-1:0]       in_vertex,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [uisl_pkg::POS_W-1:0]          out_position,
  output logic [uisl_pkg::COUNT_OUT_W-1:0]    out_entry_count,
  output uisl_pkg::wr_t                       wr,
  output logic [uisl_pkg::IDX_W-1:0]          rd_addr,
  input  logic [uisl_pkg::IDX_W-1:0]          rd_data
);
  import uisl_pkg::*;

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [IDX_W-1:0]       vtx_r, vtx_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  status_t                res_status_r, res_status_nxt;
  logic [IDX_W-1:0]       res_pos_r, res_pos_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_status_r, out_status_nxt;
  logic [POS_W-1:0]       out_pos_r, out_pos_nxt;
  logic [COUNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic [CNT_W-1:0]       idx_inc;
  logic                   in_req;
  logic                   match;

  assign idx_inc = idx_r + CNT_W'(1);
  assign in_req  = in_valid && (state_r == S_IDLE);
  assign match   = (rd_data == vtx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    vtx_r        <= vtx_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    vtx_nxt        = vtx_r;
    idx_nxt        = idx_r;
    fill_nxt       = fill_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_cnt_nxt    = out_cnt_r;
    wr             = '0;
    rd_addr        = '0;

    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_req) begin
          cmd_nxt        = cmd_t'(in_command);
          vtx_nxt        = in_vertex[IDX_W-1:0];
          idx_nxt        = '0;
          res_status_nxt = ST_DONE;
          res_pos_nxt    = '0;
          if (cmd_t'(in_command) == CMD_CLEAR) begin
            fill_nxt  = '0;
            state_nxt = S_RESULT;
          end else if (in_vertex >= VERTEX_W'(MAX_VERTICES)) begin
            res_status_nxt = ST_RANGE;
            state_nxt      = S_RESULT;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end
      end

      S_SRCH_RD: begin
        rd_addr = idx_r[IDX_W-1:0];
        if (idx_r == fill_r) begin
          // walked off the end: not present
          state_nxt = S_RESULT;
          if (cmd_r == CMD_ADD && fill_r != CNT_W'(MAX_VERTICES)) begin
            wr.en       = 1'b1;
            wr.addr     = fill_r[IDX_W-1:0];
            wr.data     = vtx_r;
            res_pos_nxt = fill_r[IDX_W-1:0];
            fill_nxt    = fill_r + CNT_W'(1);
          end else begin
            res_status_nxt = ST_NOCHANGE;
          end
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end

      S_SRCH_CMP: begin
        if (match) begin
          res_pos_nxt = idx_r[IDX_W-1:0];
          case (cmd_r)
            CMD_ADD: begin
              res_status_nxt = ST_NOCHANGE;
              state_nxt      = S_RESULT;
            end
            CMD_REMOVE: begin
              state_nxt = S_SHIFT_RD;
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SRCH_RD;
        end
      end

      S_SHIFT_RD: begin
        rd_addr = idx_inc[IDX_W-1:0];
        if (idx_inc >= fill_r) begin
          fill_nxt  = fill_r - CNT_W'(1);
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        wr.en     = 1'b1;
        wr.addr   = idx_r[IDX_W-1:0];
        wr.data   = rd_data;
        idx_nxt   = idx_inc;
        state_nxt = S_SHIFT_RD;
      end

      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = POS_W'(res_pos_r);
          out_cnt_nxt    = COUNT_OUT_W'(fill_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_pos_r;
  assign out_entry_count = out_cnt_r;

endmodule

/* src/unique_index_set_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_index_set_list
// Packed list of distinct vertex indices with add, remove, find and clear.
// ----------------------------------------------------------------------------
// One request at a time. The entries sit in a RAM with one write port and one
// registered read port. One comparator searches them from position 0, reading
// and then comparing each entry. Clear and out-of-range requests go straight
// to the result. Remove searches up to the index, then shifts every later
// entry down, reading and then writing each one. A finished result waits in
// the output register and the next request is taken meanwhile.
module unique_index_set_list (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_vertex,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_position,
  output logic [8:0]  out_entry_count
);
  import uisl_pkg::*;

  `include "assert_macros.svh"

  wr_t              wr;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_data;

  uisl_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  uisl_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_vertex       (in_vertex),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count),
    .wr              (wr),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  `UISL_ASSERT_IMP(a_no_write_idle, wr.en, in_stall, "entry write while idle")
  `UISL_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request not held off")
  `UISL_ASSERT_IMP(a_range_pos_zero, out_valid && out_status == ST_RANGE, out_position == '0, "range result with position")

endmodule

/* test/unique_index_set_list_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_index_set_list_test
// Self-checking bench for the unique index set list. A short table of directed
// requests is followed by random add/remove/find/clear traffic, including a
// full 256-entry list. A behavioural copy of the set predicts all but typed
// results; each is compared in order by field. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module unique_index_set_list_test;
  import uisl_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    status_t                status;
    logic [POS_W-1:0]       position;
    logic [COUNT_OUT_W-1:0] entry_count;
  } outcome_t;

  typedef struct {
    cmd_t                cmd;
    logic [VERTEX_W-1:0] vertex;
    bit                  typed;
    outcome_t            result;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             in_command;
  logic [VERTEX_W-1:0]    in_vertex;
  logic                   out_valid;
  logic                   out_stall;
  logic [1:0]             out_status;
  logic [POS_W-1:0]       out_position;
  logic [COUNT_OUT_W-1:0] out_entry_count;

  // behavioural copy of the list
  logic [IDX_W-1:0] set_model [MAX_VERTICES];
  int               set_size = 0;

  outcome_t pending_results [$];
  int       fault_count = 0;
  int       idle_watch  = 0;
  bit       steady      = 1'b0;
  int       fill_order [MAX_VERTICES];

  // typed rows hold results readable straight off the list contents
  directed_row_t directed_rows [20] = '{
    '{CMD_FIND,   16'd0,      1'b1, '{ST_NOCHANGE, 8'd0, 9'd0}},
    '{CMD_REMOVE, 16'd255,    1'b1, '{ST_NOCHANGE, 8'd0, 9'd0}},
    '{CMD_ADD,    16'd0,      1'b1, '{ST_DONE,     8'd0, 9'd1}},
    '{CMD_ADD,    16'd255,    1'b1, '{ST_DONE,     8'd1, 9'd2}},
    '{CMD_ADD,    16'd256,    1'b1, '{ST_RANGE,    8'd0, 9'd2}},
    '{CMD_ADD,    16'hFFFF,   1'b1, '{ST_RANGE,    8'd0, 9'd2}},
    '{CMD_REMOVE, 16'h8000,   1'b1, '{ST_RANGE,    8'd0, 9'd2}},
    '{CMD_FIND,   16'h7FFF,   1'b1, '{ST_RANGE,    8'd0, 9'd2}},
    '{CMD_ADD,    16'd0,      1'b0, '{ST_DONE,     8'd0, 9'd0}},
    '{CMD_ADD,    16'h00AA,   1'b0, '{ST_DONE,     8'd0, 9'd0}},
    '{CMD_ADD,    16'h0055,   1'b0, '{ST_DONE,     8'd0, 9'd0}},
    '{CMD_FIND,   16'd255,    1'b0, '{ST_DONE,     8'd0, 9'd0}},
    '{CMD_REMOVE, 16'd0,      1'b0, '{ST_DONE,     8'd0, 9'd0}},
    '{CMD_FIND,   16'h00AA,   1'b0, '{ST_DONE,     8'd0, 9'd0}},
    '{CMD_REMOVE, 16'h0055,   1'b0, '{ST_DONE,     8'd0, 9'd0}},
    '{CMD_REMOVE, 16'h0055,   1'b0, '{ST_DONE,     8'd0, 9'd0}},
    '{CMD_CLEAR,  16'hFFFF,   1'b1, '{ST_DONE,     8'd0, 9'd0}},
    '{CMD_FIND,   16'd255,    1'b1, '{ST_NOCHANGE, 8'd0, 9'd0}},
    '{CMD_ADD,    16'd1,      1'b1, '{ST_DONE,     8'd0, 9'd1}},
    '{CMD_CLEAR,  16'd0,      1'b1, '{ST_DONE,     8'd0, 9'd0}}
  };

  unique_index_set_list dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_vertex       (in_vertex),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

  always #4 clk = ~clk;

  // Applies one request to the list copy and returns the result it gives.
  function automatic outcome_t apply_request(input cmd_t cmd,
                                             input logic [VERTEX_W-1:0] vertex);
    outcome_t r;
    int       hit;
    r.status   = ST_DONE;
    r.position = '0;
    if (cmd == CMD_CLEAR) begin
      set_size = 0;
    end else if (int'(vertex) >= MAX_VERTICES) begin
      r.status = ST_RANGE;
    end else begin
      hit = set_size;
      for (int i = set_size - 1; i >= 0; i--)
        if (set_model[i] == vertex[IDX_W-1:0]) hit = i;
      case (cmd)
        CMD_ADD: begin
          if (hit < set_size) begin
            r.status   = ST_NOCHANGE;
            r.position = hit[POS_W-1:0];
          end else if (set_size < MAX_VERTICES) begin
            set_model[set_size] = vertex[IDX_W-1:0];
            r.position = set_size[POS_W-1:0];
            set_size++;
          end else begin
            r.status = ST_NOCHANGE;
          end
        end
        CMD_REMOVE: begin
          if (hit < set_size) begin
            // close the gap: later entries move down one place
            for (int i = hit; i + 1 < set_size; i++) set_model[i] = set_model[i + 1];
            set_size--;
            r.position = hit[POS_W-1:0];
          end else begin
            r.status = ST_NOCHANGE;
          end
        end
        default: begin
          if (hit < set_size) r.position = hit[POS_W-1:0];
          else r.status = ST_NOCHANGE;
        end
      endcase
    end
    r.entry_count = set_size[COUNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [VERTEX_W-1:0] random_vertex(input int span);
    if ($urandom_range(0, 99) < 8) return VERTEX_W'($urandom_range(MAX_VERTICES, 65535));
    return VERTEX_W'($urandom_range(0, span - 1));
  endfunction

  function automatic cmd_t random_command();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return CMD_ADD;
    if (pick < 65) return CMD_REMOVE;
    if (pick < 97) return CMD_FIND;
    return CMD_CLEAR;
  endfunction

  task automatic send_request(input cmd_t cmd, input logic [VERTEX_W-1:0] vertex,
                              input bit typed, input outcome_t typed_result);
    outcome_t predicted;
    while (!steady && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_vertex  <= vertex;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(cmd, vertex);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic send_random(input int count, input int span);
    outcome_t unused;
    unused = '{ST_DONE, '0, '0};
    repeat (count) send_request(random_command(), random_vertex(span), 1'b0, unused);
  endtask

  // result checker, receiver stalls and watchdog
  always @(posedge clk) begin
    outcome_t want;
    out_stall <= !steady && ($urandom_range(0, 99) < 9);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_watch = 0;
    else idle_watch++;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (fault_count < MAX_REPORTS)
          $display("result with no request outstanding: status %0d position %0d count %0d",
                   out_status, out_position, out_entry_count);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_position !== want.position ||
            out_entry_count !== want.entry_count) begin
          if (fault_count < MAX_REPORTS)
            $display("mismatch (exp/act): status %0d/%0d position %0d/%0d count %0d/%0d",
                     want.status, out_status, want.position, out_position,
                     want.entry_count, out_entry_count);
          fault_count++;
        end
      end
    end
    if (idle_watch >= WATCHDOG_LIMIT) begin
      $display("unique_index_set_list regression: fail");
      $finish;
    end
  end

  initial begin
    outcome_t unused;
    int       swap_at;
    int       held;
    unused = '{ST_DONE, '0, '0};
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_ADD;
    in_vertex  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].cmd, directed_rows[i].vertex,
                   directed_rows[i].typed, directed_rows[i].result);

    // small pool keeps the list short and the hit rate high
    send_random(300, 16);

    // no idling on either side for a stretch
    steady = 1'b1;
    send_random(150, 64);
    steady = 1'b0;

    // fill the list with every valid index in shuffled order
    send_request(CMD_CLEAR, '0, 1'b0, unused);
    foreach (fill_order[i]) fill_order[i] = i;
    for (int i = MAX_VERTICES - 1; i > 0; i--) begin
      swap_at = $urandom_range(0, i);
      held = fill_order[i];
      fill_order[i] = fill_order[swap_at];
      fill_order[swap_at] = held;
    end
    foreach (fill_order[i]) send_request(CMD_ADD, VERTEX_W'(fill_order[i]), 1'b0, unused);
    // adds on a full list can only find the existing entry
    repeat (10)
      send_request(CMD_ADD, VERTEX_W'($urandom_range(0, MAX_VERTICES - 1)), 1'b0, unused);
    send_random(30, MAX_VERTICES);
    send_request(CMD_CLEAR, VERTEX_W'($urandom_range(0, 65535)), 1'b0, unused);

    send_random(100, 8);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("unique_index_set_list regression: pass");
    end else begin
      $display("unique_index_set_list regression: fail");
    end
    $finish;
  end

endmodule
